### sv/srdz_pkg.sv
//------------------------------------------------------------------------------
// Stick radial dead zone package
// Shared widths, reset values, register indexes and pipeline types.
//------------------------------------------------------------------------------
`default_nettype none

package srdz_pkg;

	localparam int unsigned CFG_W       = 16;
	localparam int unsigned AXIS_W      = 16;
	localparam int unsigned MAG_W       = 17;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned FRAC_W      = 15;
	localparam int unsigned SQ_W        = 32;
	localparam int unsigned PROD_W      = 31;
	localparam int unsigned SQRT_STEPS  = 16;
	localparam int unsigned FDIV_STEPS  = 15;
	localparam int unsigned ADIV_STEPS  = 16;

	localparam logic [CFG_W-1:0] DEAD_ZONE_RST  = 16'd8000;
	localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd30000;

	typedef enum logic {
		REG_DEAD_ZONE  = 1'b0,
		REG_FULL_SCALE = 1'b1
	} cfg_reg_t;

	// Axis magnitudes and signs that ride along the pipeline.
	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             nx;
		logic             ny;
	} axis_t;

	// Magnitude of a two's complement sample, 0 to 32768.
	function automatic logic [MAG_W-1:0] abs_mag(input logic [AXIS_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[AXIS_W-1], v};
		return v[AXIS_W-1] ? (MAG_W'(0) - ext) : ext;
	endfunction

endpackage

`default_nettype wire

### sv/stick_radial_dead_zone_core.sv
//------------------------------------------------------------------------------
// Stick radial dead zone core
// Rescales a two-axis stick sample so that its length maps from the band
// between the dead zone and the full-scale radius onto 0..1 in Q1.15.
//------------------------------------------------------------------------------
// Usage:
// A sample word (stick_x, stick_y) is taken at every rising edge at which
// start is high; busy stays low, so a new word can enter in every cycle.
// The matching result word (out_x, out_y) is shown for exactly one cycle
// with done high. Results leave in the order the samples came in, one per
// sample.
// The pipeline is built from the bit-serial units laid out as stages: three
// stages for magnitude and squares, 16 for the square root, 16 for the
// fraction divider, one for the axis multiply and 17 for the axis dividers,
// plus the output register. Throughput is one word per cycle.
// The two registers are written through cfg_wr_en, cfg_index and cfg_wdata
// and must only change while no sample is in flight.
// Reset clears the valid bits of every stage and loads the register reset
// values (dead zone 8000, full scale 30000). The receiver cannot stall:
// every result is presented once and must be taken in that cycle.
//------------------------------------------------------------------------------
`default_nettype none

module stick_radial_dead_zone_core import srdz_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [AXIS_W-1:0] stick_x,
	input  logic signed [AXIS_W-1:0] stick_y,
	input  logic                     cfg_wr_en,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	output logic                     done,
	output logic signed [AXIS_W-1:0] out_x,
	output logic signed [AXIS_W-1:0] out_y
);

	// Configuration registers.
	logic [CFG_W-1:0] dead_q;
	logic [CFG_W-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= DEAD_ZONE_RST;
			full_q <= FULL_SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEAD_ZONE:  dead_q <= cfg_wdata;
				REG_FULL_SCALE: full_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline never pushes back.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// The user keeps the band width static while samples are in flight; the
	// block has no check. Formed once, it feeds every fraction divider stage.
	logic             band_empty;
	logic [LEN_W-1:0] denom;
	assign band_empty = (full_q <= dead_q);
	assign denom      = full_q - dead_q;

	// Stage 1: magnitudes and signs.
	logic  v_s1;
	axis_t axis_s1;

	// Stage 2: squares of the magnitudes (each at most 2^30).
	logic              v_s2;
	axis_t             axis_s2;
	logic [PROD_W-1:0] sqx_s2;
	logic [PROD_W-1:0] sqy_s2;
	logic [2*MAG_W-1:0] sqx_full;
	logic [2*MAG_W-1:0] sqy_full;
	assign sqx_full = axis_s1.ax * axis_s1.ax;
	assign sqy_full = axis_s1.ay * axis_s1.ay;

	// Square root lane: entry 0 holds the sum of squares, each following
	// entry has retired one more root bit.
	logic              sv_sr   [0:SQRT_STEPS];
	axis_t             saxis_sr[0:SQRT_STEPS];
	logic [SQ_W-1:0]   sq_sr   [0:SQRT_STEPS];
	logic [LEN_W:0]    srem_sr [0:SQRT_STEPS];
	logic [LEN_W-1:0]  root_sr [0:SQRT_STEPS];
	logic [LEN_W:0]    srem_nx [0:SQRT_STEPS-1];
	logic              stake_nx[0:SQRT_STEPS-1];

	always_comb begin
		for (int k = 0; k < SQRT_STEPS; k++) begin
			logic [LEN_W+2:0] sh;
			logic [LEN_W+2:0] tr;
			sh = {srem_sr[k], sq_sr[k][SQ_W-1-2*k -: 2]};
			tr = {1'b0, root_sr[k], 2'b01};
			stake_nx[k] = (sh >= tr);
			srem_nx[k]  = stake_nx[k] ? (LEN_W+1)'(sh - tr) : sh[LEN_W:0];
		end
	end

	// Fraction divider lane: entry 0 holds len - dead zone, each following
	// entry has one more quotient bit of (len - dead) * 2^15 / band.
	logic              fv_sr   [0:FDIV_STEPS];
	axis_t             faxis_sr[0:FDIV_STEPS];
	logic [LEN_W-1:0]  flen_sr [0:FDIV_STEPS];
	logic              fzero_sr[0:FDIV_STEPS];
	logic              ffull_sr[0:FDIV_STEPS];
	logic [LEN_W-1:0]  frem_sr [0:FDIV_STEPS];
	logic [FRAC_W-1:0] fq_sr   [0:FDIV_STEPS];
	logic [LEN_W-1:0]  frem_nx [0:FDIV_STEPS-1];
	logic              ftake_nx[0:FDIV_STEPS-1];

	logic [LEN_W-1:0] len_w;
	logic [LEN_W-1:0] dist_w;
	assign len_w  = root_sr[SQRT_STEPS];
	assign dist_w = len_w - dead_q;

	always_comb begin
		for (int k = 0; k < FDIV_STEPS; k++) begin
			logic [LEN_W:0] sh;
			sh = {frem_sr[k], 1'b0};
			ftake_nx[k] = (sh >= {1'b0, denom});
			frem_nx[k]  = ftake_nx[k] ? LEN_W'(sh - {1'b0, denom}) : sh[LEN_W-1:0];
		end
	end

	// Fraction in Q1.15 with 32768 meaning one.
	logic [LEN_W-1:0] frac_w;
	assign frac_w = ffull_sr[FDIV_STEPS] ? {1'b1, {FRAC_W{1'b0}}}
	                                     : {1'b0, fq_sr[FDIV_STEPS]};

	// Multiply stage: axis magnitude times fraction (at most 2^30).
	logic              v_m;
	logic              zero_m;
	logic              nx_m;
	logic              ny_m;
	logic [LEN_W-1:0]  len_m;
	logic [PROD_W-1:0] px_m;
	logic [PROD_W-1:0] py_m;
	logic [MAG_W+LEN_W-1:0] px_full;
	logic [MAG_W+LEN_W-1:0] py_full;
	assign px_full = faxis_sr[FDIV_STEPS].ax * frac_w;
	assign py_full = faxis_sr[FDIV_STEPS].ay * frac_w;

	// Axis divider lanes: entry 0 holds the high half of the product as the
	// partial remainder and an overflow flag for quotients of 2^16 and more.
	logic              av_sr   [0:ADIV_STEPS];
	logic              azero_sr[0:ADIV_STEPS];
	logic              anx_sr  [0:ADIV_STEPS];
	logic              any_sr  [0:ADIV_STEPS];
	logic [LEN_W-1:0]  alen_sr [0:ADIV_STEPS];
	logic              aovx_sr [0:ADIV_STEPS];
	logic              aovy_sr [0:ADIV_STEPS];
	logic [LEN_W-1:0]  aremx_sr[0:ADIV_STEPS];
	logic [LEN_W-1:0]  aremy_sr[0:ADIV_STEPS];
	logic [LEN_W-1:0]  alowx_sr[0:ADIV_STEPS];
	logic [LEN_W-1:0]  alowy_sr[0:ADIV_STEPS];
	logic [LEN_W-1:0]  aqx_sr  [0:ADIV_STEPS];
	logic [LEN_W-1:0]  aqy_sr  [0:ADIV_STEPS];
	logic [LEN_W-1:0]  aremx_nx[0:ADIV_STEPS-1];
	logic [LEN_W-1:0]  aremy_nx[0:ADIV_STEPS-1];
	logic              atakex_nx[0:ADIV_STEPS-1];
	logic              atakey_nx[0:ADIV_STEPS-1];

	always_comb begin
		for (int k = 0; k < ADIV_STEPS; k++) begin
			logic [LEN_W:0] shx;
			logic [LEN_W:0] shy;
			shx = {aremx_sr[k], alowx_sr[k][LEN_W-1-k]};
			shy = {aremy_sr[k], alowy_sr[k][LEN_W-1-k]};
			atakex_nx[k] = (shx >= {1'b0, alen_sr[k]});
			atakey_nx[k] = (shy >= {1'b0, alen_sr[k]});
			aremx_nx[k]  = atakex_nx[k] ? LEN_W'(shx - {1'b0, alen_sr[k]}) : shx[LEN_W-1:0];
			aremy_nx[k]  = atakey_nx[k] ? LEN_W'(shy - {1'b0, alen_sr[k]}) : shy[LEN_W-1:0];
		end
	end

	// Applies the sign with truncation toward zero and saturates.
	function automatic logic [AXIS_W-1:0] finish(input logic [LEN_W-1:0] q,
	                                             input logic ov, input logic neg);
		logic [AXIS_W-1:0] r;
		if (neg) begin
			if (ov || q > 16'd32768) r = 16'h8000;
			else                     r = 16'd0 - q;
		end else begin
			if (ov || q[LEN_W-1])    r = 16'h7fff;
			else                     r = q;
		end
		return r;
	endfunction

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_m  <= 1'b0;
			done <= 1'b0;
			for (int k = 0; k <= SQRT_STEPS; k++) sv_sr[k] <= 1'b0;
			for (int k = 0; k <= FDIV_STEPS; k++) fv_sr[k] <= 1'b0;
			for (int k = 0; k <= ADIV_STEPS; k++) av_sr[k] <= 1'b0;
		end else begin
			v_s1     <= accept;
			v_s2     <= v_s1;
			sv_sr[0] <= v_s2;
			for (int k = 0; k < SQRT_STEPS; k++) sv_sr[k+1] <= sv_sr[k];
			fv_sr[0] <= sv_sr[SQRT_STEPS];
			for (int k = 0; k < FDIV_STEPS; k++) fv_sr[k+1] <= fv_sr[k];
			v_m      <= fv_sr[FDIV_STEPS];
			av_sr[0] <= v_m;
			for (int k = 0; k < ADIV_STEPS; k++) av_sr[k+1] <= av_sr[k];
			done     <= av_sr[ADIV_STEPS];
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		axis_s1 <= '{ax: abs_mag(stick_x), ay: abs_mag(stick_y),
		             nx: stick_x[AXIS_W-1], ny: stick_y[AXIS_W-1]};

		axis_s2 <= axis_s1;
		sqx_s2  <= sqx_full[PROD_W-1:0];
		sqy_s2  <= sqy_full[PROD_W-1:0];

		saxis_sr[0] <= axis_s2;
		sq_sr[0]    <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		srem_sr[0]  <= '0;
		root_sr[0]  <= '0;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			saxis_sr[k+1] <= saxis_sr[k];
			sq_sr[k+1]    <= sq_sr[k];
			srem_sr[k+1]  <= srem_nx[k];
			root_sr[k+1]  <= {root_sr[k][LEN_W-2:0], stake_nx[k]};
		end

		faxis_sr[0] <= saxis_sr[SQRT_STEPS];
		flen_sr[0]  <= len_w;
		fzero_sr[0] <= (len_w == '0) || (len_w < dead_q);
		ffull_sr[0] <= band_empty || (dist_w >= denom);
		frem_sr[0]  <= dist_w;
		fq_sr[0]    <= '0;
		for (int k = 0; k < FDIV_STEPS; k++) begin
			faxis_sr[k+1] <= faxis_sr[k];
			flen_sr[k+1]  <= flen_sr[k];
			fzero_sr[k+1] <= fzero_sr[k];
			ffull_sr[k+1] <= ffull_sr[k];
			frem_sr[k+1]  <= frem_nx[k];
			fq_sr[k+1]    <= {fq_sr[k][FRAC_W-2:0], ftake_nx[k]};
		end

		zero_m <= fzero_sr[FDIV_STEPS];
		nx_m   <= faxis_sr[FDIV_STEPS].nx;
		ny_m   <= faxis_sr[FDIV_STEPS].ny;
		len_m  <= flen_sr[FDIV_STEPS];
		px_m   <= px_full[PROD_W-1:0];
		py_m   <= py_full[PROD_W-1:0];

		azero_sr[0] <= zero_m;
		anx_sr[0]   <= nx_m;
		any_sr[0]   <= ny_m;
		alen_sr[0]  <= len_m;
		aovx_sr[0]  <= ({1'b0, px_m[PROD_W-1:LEN_W]} >= len_m);
		aovy_sr[0]  <= ({1'b0, py_m[PROD_W-1:LEN_W]} >= len_m);
		aremx_sr[0] <= {1'b0, px_m[PROD_W-1:LEN_W]};
		aremy_sr[0] <= {1'b0, py_m[PROD_W-1:LEN_W]};
		alowx_sr[0] <= px_m[LEN_W-1:0];
		alowy_sr[0] <= py_m[LEN_W-1:0];
		aqx_sr[0]   <= '0;
		aqy_sr[0]   <= '0;
		for (int k = 0; k < ADIV_STEPS; k++) begin
			azero_sr[k+1] <= azero_sr[k];
			anx_sr[k+1]   <= anx_sr[k];
			any_sr[k+1]   <= any_sr[k];
			alen_sr[k+1]  <= alen_sr[k];
			aovx_sr[k+1]  <= aovx_sr[k];
			aovy_sr[k+1]  <= aovy_sr[k];
			aremx_sr[k+1] <= aremx_nx[k];
			aremy_sr[k+1] <= aremy_nx[k];
			alowx_sr[k+1] <= alowx_sr[k];
			alowy_sr[k+1] <= alowy_sr[k];
			aqx_sr[k+1]   <= {aqx_sr[k][LEN_W-2:0], atakex_nx[k]};
			aqy_sr[k+1]   <= {aqy_sr[k][LEN_W-2:0], atakey_nx[k]};
		end

		// Inside the dead zone or at zero length the word is centered.
		if (azero_sr[ADIV_STEPS]) begin
			out_x <= '0;
			out_y <= '0;
		end else begin
			out_x <= finish(aqx_sr[ADIV_STEPS], aovx_sr[ADIV_STEPS], anx_sr[ADIV_STEPS]);
			out_y <= finish(aqy_sr[ADIV_STEPS], aovy_sr[ADIV_STEPS], any_sr[ADIV_STEPS]);
		end
	end

endmodule

`default_nettype wire
